>>> sv/iso8601_timestamp_to_epoch_assert.svh
// Assertion macros for the timestamp converter.
`ifndef ISO8601_TIMESTAMP_TO_EPOCH_ASSERT_SVH
`define ISO8601_TIMESTAMP_TO_EPOCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timestamp converter check failed");

// Next-cycle implication, disabled while reset is held.
`define TS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timestamp converter check failed");

`endif

>>> sv/ts2e_pkg.sv
// Package: sequencer states, layout constants and date helpers.
package ts2e_pkg;

  localparam int unsigned LayoutLen = 19;
  localparam int unsigned SuffixMax = 6;

  localparam logic [1:0] PH_LAYOUT = 2'd0;
  localparam logic [1:0] PH_AT19   = 2'd1;
  localparam logic [1:0] PH_FRAC   = 2'd2;
  localparam logic [1:0] PH_SUFFIX = 2'd3;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CHK  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_M1   = 9'b000001000,
    S_M2   = 9'b000010000,
    S_M3   = 9'b000100000,
    S_M4   = 9'b001000000,
    S_M5   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  // Days from 1 March to the first of the given month (March-based year).
  function automatic logic [8:0] month_base(input logic [6:0] m);
    logic [8:0] r;
    r = '0;
    case (m)
      7'd3:  r = 9'd0;
      7'd4:  r = 9'd31;
      7'd5:  r = 9'd61;
      7'd6:  r = 9'd92;
      7'd7:  r = 9'd122;
      7'd8:  r = 9'd153;
      7'd9:  r = 9'd184;
      7'd10: r = 9'd214;
      7'd11: r = 9'd245;
      7'd12: r = 9'd275;
      7'd1:  r = 9'd306;
      7'd2:  r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Two ASCII digits to 0..99, with a flag when either is not a digit.
  function automatic logic [7:0] digit_pair(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] da;
    logic [3:0] db;
    da = 4'(a - 8'd48);
    db = 4'(b - 8'd48);
    if (!is_digit(a) || !is_digit(b)) begin
      return 8'hFF;
    end
    return 8'({4'd0, da} * 8'd10 + {4'd0, db});
  endfunction

endpackage

>>> sv/iso8601_timestamp_to_epoch.sv
// Timestamp string parser and civil-date to Unix seconds converter.
// Bytes are taken one per cycle until the last byte of a string.
// After the last byte the block is busy: it checks the fields, divides the March-based year by 400
// by repeated subtraction and forms the products on one reused multiplier; a malformed string skips to the result.
// The result beat is then held until taken; the next string starts the cycle after that.
// Synchronous active-low reset returns the parser and sequencer to idle.
module iso8601_timestamp_to_epoch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_parse_ok,
  output logic signed [38:0] out_epoch_seconds
);
  import ts2e_pkg::*;

  state_t state_r, state_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        ferr_r, ferr_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt, day_r, day_nxt, hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt, sec_r, sec_nxt;
  logic [7:0]  sfx_r [SuffixMax];
  logic [7:0]  sfx_nxt [SuffixMax];
  logic [2:0]  scnt_r, scnt_nxt;

  logic signed [5:0]  era_r, era_nxt;
  logic [13:0]        rem_r, rem_nxt;
  logic signed [23:0] acc_r, acc_nxt;
  logic signed [38:0] prod_r, prod_nxt;
  logic signed [20:0] tod_r, tod_nxt;
  logic signed [38:0] res_r, res_nxt;
  logic               ok_r, ok_nxt;
  logic               ov_r, ov_nxt;

  logic        in_fire;
  logic        dig;
  logic [3:0]  dv;
  logic [13:0] cur_val, mac_val;
  logic        take_sfx;

  logic        ok_c;
  logic [7:0]  oh_c, om_c;
  logic        zone_bad;
  logic [18:0] off_c;
  logic [16:0] hms_c;
  logic signed [20:0] tod_c;
  logic signed [14:0] y_c;

  logic signed [23:0] mul_a;
  logic [17:0]        mul_b;
  logic signed [42:0] mul_p;
  logic [1:0]         c100;
  logic [17:0]        doe_c;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign dig      = is_digit(in_char_byte);
  assign dv       = 4'(in_char_byte - 8'd48);

  // One digit accumulator shared by all layout fields.
  always_comb begin
    if (idx_r < 5'd4)       cur_val = year_r;
    else if (idx_r < 5'd7)  cur_val = {7'd0, month_r};
    else if (idx_r < 5'd10) cur_val = {7'd0, day_r};
    else if (idx_r < 5'd13) cur_val = {7'd0, hour_r};
    else if (idx_r < 5'd16) cur_val = {7'd0, min_r};
    else                    cur_val = {7'd0, sec_r};
    mac_val = 14'(cur_val * 14'd10 + {10'd0, dv});
  end

  // Validity and zone offset, evaluated from the settled parse registers.
  always_comb begin
    ok_c = (phase_r != PH_LAYOUT) && !ferr_r &&
           (month_r >= 7'd1) && (month_r <= 7'd12) &&
           (day_r >= 7'd1) && (day_r <= 7'd31) &&
           (hour_r <= 7'd23) && (min_r <= 7'd59) && (sec_r <= 7'd60);
    oh_c = digit_pair(sfx_r[1], sfx_r[2]);
    if (scnt_r >= 3'd6 && sfx_r[3] == 8'h3A) om_c = digit_pair(sfx_r[4], sfx_r[5]);
    else if (scnt_r >= 3'd5)                 om_c = digit_pair(sfx_r[3], sfx_r[4]);
    else                                     om_c = 8'd0;
    zone_bad = (scnt_r < 3'd3) ||
               (sfx_r[0] != 8'h2B && sfx_r[0] != 8'h2D) ||
               (oh_c == 8'hFF) || (om_c == 8'hFF);
    if (zone_bad) off_c = '0;
    else off_c = 19'({11'd0, oh_c} * 19'd3600 + {11'd0, om_c} * 19'd60);
    hms_c = 17'({10'd0, hour_r} * 17'd3600 + {10'd0, min_r} * 17'd60 + {10'd0, sec_r});
    if (sfx_r[0] == 8'h2D) tod_c = $signed({4'd0, hms_c}) + $signed({2'd0, off_c});
    else                   tod_c = $signed({4'd0, hms_c}) - $signed({2'd0, off_c});
    y_c = $signed({1'b0, year_r}) - ((month_r <= 7'd2) ? 15'sd1 : 15'sd0);
  end

  // Shared multiplier, operands picked by the sequencer.
  always_comb begin
    unique case (state_r)
      S_M1:    begin mul_a = {15'd0, rem_r[8:0]};   mul_b = 18'd365;    end
      S_M2:    begin mul_a = 24'(era_r);            mul_b = 18'd146097; end
      default: begin mul_a = acc_r;                 mul_b = 18'd86400;  end
    endcase
    mul_p = mul_a * $signed({1'b0, mul_b});
  end

  always_comb begin
    if (rem_r[8:0] >= 9'd300)      c100 = 2'd3;
    else if (rem_r[8:0] >= 9'd200) c100 = 2'd2;
    else if (rem_r[8:0] >= 9'd100) c100 = 2'd1;
    else                           c100 = 2'd0;
    doe_c = 18'(prod_r[17:0] + {11'd0, rem_r[8:2]} - {16'd0, c100}
                + {9'd0, month_base(month_r)} + {11'd0, day_r} - 18'd1);
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;  phase_nxt = phase_r;  ferr_nxt = ferr_r;
    year_nxt = year_r;  month_nxt = month_r;  day_nxt = day_r;
    hour_nxt = hour_r;  min_nxt = min_r;  sec_nxt = sec_r;
    sfx_nxt = sfx_r;  scnt_nxt = scnt_r;
    era_nxt = era_r;  rem_nxt = rem_r;  acc_nxt = acc_r;  prod_nxt = prod_r;
    tod_nxt = tod_r;  res_nxt = res_r;  ok_nxt = ok_r;  ov_nxt = ov_r;
    take_sfx = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (phase_r)
            PH_LAYOUT: begin
              if (idx_r == 5'd4 || idx_r == 5'd7) begin
                if (in_char_byte != 8'h2D) ferr_nxt = 1'b1;
              end else if (idx_r == 5'd13 || idx_r == 5'd16) begin
                if (in_char_byte != 8'h3A) ferr_nxt = 1'b1;
              end else if (idx_r == 5'd10) begin
                if (in_char_byte != 8'h54 && in_char_byte != 8'h74 &&
                    in_char_byte != 8'h20) ferr_nxt = 1'b1;
              end else if (!dig) begin
                ferr_nxt = 1'b1;
              end else if (idx_r < 5'd4)  begin year_nxt = mac_val;
              end else if (idx_r < 5'd7)  begin month_nxt = mac_val[6:0];
              end else if (idx_r < 5'd10) begin day_nxt = mac_val[6:0];
              end else if (idx_r < 5'd13) begin hour_nxt = mac_val[6:0];
              end else if (idx_r < 5'd16) begin min_nxt = mac_val[6:0];
              end else begin sec_nxt = mac_val[6:0];
              end
              idx_nxt = idx_r + 5'd1;
              if (idx_r == 5'(LayoutLen - 1)) phase_nxt = PH_AT19;
            end
            PH_AT19: begin
              if (in_char_byte == 8'h2E) phase_nxt = PH_FRAC;
              else begin phase_nxt = PH_SUFFIX; take_sfx = 1'b1; end
            end
            PH_FRAC: begin
              if (!dig) begin phase_nxt = PH_SUFFIX; take_sfx = 1'b1; end
            end
            default: take_sfx = 1'b1;
          endcase
          if (take_sfx && scnt_r < 3'(SuffixMax)) begin
            sfx_nxt[scnt_r] = in_char_byte;
            scnt_nxt = scnt_r + 3'd1;
          end
          if (in_is_last) state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        ok_nxt = ok_c;
        if (!ok_c) begin
          res_nxt = '0;
          ov_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          // A 'Z' or 'z' suffix means no offset at all.
          if (scnt_r >= 3'd1 && (sfx_r[0] == 8'h5A || sfx_r[0] == 8'h7A))
            tod_nxt = $signed({4'd0, hms_c});
          else
            tod_nxt = tod_c;
          if (y_c < 0) begin
            era_nxt = -6'sd1;
            rem_nxt = 14'd399;
          end else begin
            era_nxt = '0;
            rem_nxt = 14'(y_c);
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_r >= 14'd400) begin
          rem_nxt = rem_r - 14'd400;
          era_nxt = era_r + 6'sd1;
        end else begin
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        prod_nxt = 39'(mul_p);
        state_nxt = S_M2;
      end
      S_M2: begin
        acc_nxt = $signed({6'd0, doe_c}) - 24'sd719468;
        prod_nxt = 39'(mul_p);
        state_nxt = S_M3;
      end
      S_M3: begin
        acc_nxt = acc_r + prod_r[23:0];
        state_nxt = S_M4;
      end
      S_M4: begin
        prod_nxt = 39'(mul_p);
        state_nxt = S_M5;
      end
      S_M5: begin
        res_nxt = prod_r + 39'(tod_r);
        ov_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          ov_nxt = 1'b0;
          idx_nxt = '0;  phase_nxt = PH_LAYOUT;  ferr_nxt = 1'b0;
          year_nxt = '0;  month_nxt = '0;  day_nxt = '0;
          hour_nxt = '0;  min_nxt = '0;  sec_nxt = '0;  scnt_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      phase_r <= PH_LAYOUT;
      ferr_r  <= 1'b0;
      year_r  <= '0;
      month_r <= '0;
      day_r   <= '0;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      scnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      ferr_r  <= ferr_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      scnt_r  <= scnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sfx_r  <= sfx_nxt;
    era_r  <= era_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    tod_r  <= tod_nxt;
    res_r  <= res_nxt;
    ok_r   <= ok_nxt;
  end

  assign out_valid         = ov_r;
  assign out_parse_ok      = ok_r;
  assign out_epoch_seconds = res_r;

`include "iso8601_timestamp_to_epoch_assert.svh"

  `TS_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `TS_ASSERT_NOW(a_bad_is_zero, clk, rst_n, out_valid && !out_parse_ok, out_epoch_seconds == '0)
  `TS_ASSERT_NEXT(a_last_busy, clk, rst_n, in_valid && in_ready && in_is_last, !in_ready)
  `TS_ASSERT_NEXT(a_taken_idle, clk, rst_n, out_valid && out_ready, in_ready && !out_valid)

endmodule

>>> bench/iso8601_timestamp_to_epoch_tb.sv
// Testbench for the timestamp converter: directed and random strings, predicted epoch values.
module iso8601_timestamp_to_epoch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] char_byte;
    logic       is_last;
  } byte_beat_t;

  typedef struct {
    logic              parse_ok;
    logic signed [38:0] epoch_seconds;
  } epoch_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_parse_ok;
  logic signed [38:0] out_epoch_seconds;

  byte_beat_t    pending_bytes[$];
  epoch_result_t expected_epochs[$];
  int  mismatches;
  longint cycle_count;
  bit  stimulus_done;
  bit  idle_free;
  bit  hold_sender;

  // Predictor state.
  logic [4:0]  p_index;
  logic [1:0]  p_phase;
  logic        p_err;
  logic [13:0] p_year;
  logic [6:0]  p_month, p_day, p_hour, p_minute, p_second;
  logic [7:0]  p_suffix[6];
  int          p_suffix_count;

  iso8601_timestamp_to_epoch uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_byte(in_char_byte), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_parse_ok(out_parse_ok), .out_epoch_seconds(out_epoch_seconds)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit digit_char(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic void clear_parser();
    p_index = '0; p_phase = ts2e_pkg::PH_LAYOUT; p_err = 1'b0;
    p_year = '0; p_month = '0; p_day = '0;
    p_hour = '0; p_minute = '0; p_second = '0;
    p_suffix_count = 0;
    for (int k = 0; k < 6; k++) p_suffix[k] = '0;
  endfunction

  function automatic longint civil_day_number(input longint y, input longint m, input longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // Two suffix digits from position p, or -1 when either is not a digit.
  function automatic longint offset_pair(input int p);
    logic [7:0] a, b;
    a = p_suffix[p % 6];
    b = p_suffix[(p + 1) % 6];
    if (!digit_char(a) || !digit_char(b)) return -1;
    return (a - 48) * 10 + (b - 48);
  endfunction

  function automatic longint zone_seconds();
    longint oh, om;
    om = 0;
    if (p_suffix_count < 3) return 0;
    if (p_suffix[0] != "+" && p_suffix[0] != "-") return 0;
    oh = offset_pair(1);
    if (p_suffix_count >= 6 && p_suffix[3] == ":") om = offset_pair(4);
    else if (p_suffix_count >= 5) om = offset_pair(3);
    if (oh < 0 || om < 0) return 0;
    return (p_suffix[0] == "+" ? 1 : -1) * (oh * 3600 + om * 60);
  endfunction

  function automatic void keep_suffix(input logic [7:0] c);
    if (p_suffix_count < 6) begin
      p_suffix[p_suffix_count] = c;
      p_suffix_count++;
    end
  endfunction

  function automatic void take_layout_char(input int i, input logic [7:0] c);
    logic [6:0] dv;
    dv = 7'(c - 8'd48);
    if (i == 4 || i == 7) begin
      if (c != "-") p_err = 1'b1;
    end else if (i == 13 || i == 16) begin
      if (c != ":") p_err = 1'b1;
    end else if (i == 10) begin
      if (c != "T" && c != "t" && c != " ") p_err = 1'b1;
    end else if (!digit_char(c)) begin
      p_err = 1'b1;
    end else if (i < 4) p_year = 14'(p_year * 10 + dv);
    else if (i < 7) p_month = 7'(p_month * 10 + dv);
    else if (i < 10) p_day = 7'(p_day * 10 + dv);
    else if (i < 13) p_hour = 7'(p_hour * 10 + dv);
    else if (i < 16) p_minute = 7'(p_minute * 10 + dv);
    else p_second = 7'(p_second * 10 + dv);
  endfunction

  // Advances the predicted parser by one byte; on the last byte pushes the expected epoch.
  function automatic void predict_epoch(input byte_beat_t b);
    epoch_result_t r;
    longint secs, off;
    case (p_phase)
      ts2e_pkg::PH_LAYOUT: begin
        take_layout_char(p_index, b.char_byte);
        p_index++;
        if (p_index >= 19) begin
          p_index = 19;
          p_phase = ts2e_pkg::PH_AT19;
        end
      end
      ts2e_pkg::PH_AT19: begin
        if (b.char_byte == ".") p_phase = ts2e_pkg::PH_FRAC;
        else begin
          p_phase = ts2e_pkg::PH_SUFFIX;
          keep_suffix(b.char_byte);
        end
      end
      ts2e_pkg::PH_FRAC: begin
        if (!digit_char(b.char_byte)) begin
          p_phase = ts2e_pkg::PH_SUFFIX;
          keep_suffix(b.char_byte);
        end
      end
      default: keep_suffix(b.char_byte);
    endcase
    if (!b.is_last) return;
    r.parse_ok = p_phase != ts2e_pkg::PH_LAYOUT && !p_err &&
                 p_month >= 1 && p_month <= 12 && p_day >= 1 && p_day <= 31 &&
                 p_hour <= 23 && p_minute <= 59 && p_second <= 60;
    secs = 0;
    if (r.parse_ok) begin
      off = (p_suffix_count >= 1 && (p_suffix[0] == "Z" || p_suffix[0] == "z")) ? 0 :
            zone_seconds();
      secs = civil_day_number(p_year, p_month, p_day) * 86400 + p_hour * 3600 +
             p_minute * 60 + p_second - off;
    end
    r.epoch_seconds = 39'(secs);
    expected_epochs.push_back(r);
    clear_parser();
  endfunction

  function automatic void queue_string(input string s);
    byte_beat_t b;
    for (int k = 0; k < s.len(); k++) begin
      b.char_byte = s[k];
      b.is_last = (k == s.len() - 1);
      pending_bytes.push_back(b);
    end
  endfunction

  function automatic string digits(input int v, input int n);
    string s;
    s = "";
    for (int k = 0; k < n; k++) begin
      s = {string'(8'(48 + v % 10)), s};
      v = v / 10;
    end
    return s;
  endfunction

  function automatic byte random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // A layout with random content, an optional random fraction and a random zone; one layout byte is sometimes broken.
  function automatic string random_timestamp();
    string s, sep;
    int pick;
    pick = $urandom_range(0, 2);
    sep = pick == 0 ? "T" : (pick == 1 ? "t" : " ");
    s = {digits($urandom_range(0, 9999), 4), "-", digits($urandom_range(0, 13), 2), "-",
         digits($urandom_range(0, 32), 2), sep, digits($urandom_range(0, 24), 2), ":",
         digits($urandom_range(0, 60), 2), ":", digits($urandom_range(0, 61), 2)};
    if ($urandom_range(0, 3) == 0) begin
      s = {s, "."};
      repeat ($urandom_range(0, 4)) s = {s, digits($urandom_range(0, 9), 1)};
    end
    case ($urandom_range(0, 7))
      0: ;
      1: s = {s, ($urandom_range(0, 1) ? "Z" : "z")};
      2: s = {s, ($urandom_range(0, 1) ? "+" : "-"), digits($urandom_range(0, 99), 2)};
      3: s = {s, ($urandom_range(0, 1) ? "+" : "-"), digits($urandom_range(0, 99), 2), ":",
              digits($urandom_range(0, 99), 2)};
      4: s = {s, ($urandom_range(0, 1) ? "+" : "-"), digits($urandom_range(0, 99), 4)};
      5: s = {s, ($urandom_range(0, 1) ? "+" : "-"), string'(random_byte())};
      default: repeat ($urandom_range(1, 7)) s = {s, string'(random_byte())};
    endcase
    // Occasionally break one layout byte.
    if ($urandom_range(0, 9) == 0) s[$urandom_range(0, 18)] = random_byte();
    return s;
  endfunction

  // Random raw bytes, at least one, possibly too short.
  function automatic void queue_noise();
    byte_beat_t b;
    int n;
    n = $urandom_range(1, 24);
    for (int k = 0; k < n; k++) begin
      b.char_byte = random_byte();
      b.is_last = (k == n - 1);
      pending_bytes.push_back(b);
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    stimulus_done = 1'b0;
    idle_free = 1'b0;
    hold_sender = 1'b0;
    clear_parser();
    queue_string("1970-01-01T00:00:00");
    queue_string("0000-01-01T00:00:00Z");
    queue_string("9999-12-31T23:59:60+99:99");
    queue_string("9999-12-31 23:59:59-9999");
    queue_string("2000-02-31t12:30:45.123456-05");
    queue_string("2024-13-01T00:00:00");
    queue_string("2024-00-10T00:00:00");
    queue_string("2024-01-32T00:00:00");
    queue_string("2024-01-00T24:00:00");
    queue_string("2024-01-01T23:60:61");
    queue_string("2024/01-01T00:00:00");
    queue_string("2024-01-01X00:00:00");
    queue_string("2024-01-01T00.00:00");
    queue_string("20a4-01-01T00:00:00");
    queue_string("2024-01-01T00:00");
    queue_string("Z");
    queue_string("2024-01-01T00:00:00+0");
    queue_string("2024-01-01T00:00:00+1a:30");
    queue_string("2024-01-01T00:00:00+12:3x");
    queue_string("2024-01-01T00:00:00.99zjunk");
    queue_string("2024-03-01T00:00:00+05:30trailing");
    queue_string({"1999-12-31T23:59:59", 8'hFF, 8'h80});
    queue_string("2024-01-01T00:00:00.");
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (30) begin
      if ($urandom_range(0, 5) == 0) queue_noise();
      else queue_string(random_timestamp());
    end
    wait (pending_bytes.size() == 0);
    // Let every outstanding result drain before sending more.
    hold_sender = 1'b1;
    wait (!in_valid && expected_epochs.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;
    idle_free = 1'b1;
    repeat (20) queue_string(random_timestamp());
    wait (pending_bytes.size() == 0);
    idle_free = 1'b0;
    repeat (20) begin
      if ($urandom_range(0, 5) == 0) queue_noise();
      else queue_string(random_timestamp());
    end
    wait (pending_bytes.size() == 0 && !in_valid);
    stimulus_done = 1'b1;
  end

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_char_byte <= '0;
      in_is_last <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_epoch('{in_char_byte, in_is_last});
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && !hold_sender &&
            (idle_free || $urandom_range(0, 99) >= 34)) begin
          in_char_byte <= pending_bytes[0].char_byte;
          in_is_last <= pending_bytes[0].is_last;
          void'(pending_bytes.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    epoch_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_epochs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: ok=%0b secs=%0d", out_parse_ok, out_epoch_seconds);
        end else begin
          want = expected_epochs.pop_front();
          if (want.parse_ok !== out_parse_ok || want.epoch_seconds !== out_epoch_seconds) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected ok=%0b secs=%0d, got ok=%0b secs=%0d",
                       want.parse_ok, want.epoch_seconds, out_parse_ok, out_epoch_seconds);
          end
        end
      end
      out_ready <= idle_free || $urandom_range(0, 99) >= 34;
    end
  end

  initial begin
    mismatches = 0;
    cycle_count = 0;
    fork
      begin
        wait (stimulus_done && expected_epochs.size() == 0);
        repeat (50) @(posedge clk);
      end
      begin
        while (cycle_count < 400000) begin
          @(posedge clk);
          cycle_count++;
        end
        mismatches++;
        $display("timeout waiting for results");
      end
    join_any
    if (mismatches == 0) $display("iso8601_timestamp_to_epoch_tb: PASS");
    else $display("iso8601_timestamp_to_epoch_tb: FAIL");
    $finish;
  end

endmodule
